// File: design/cmct_pkg.sv
// ----------------------------------------------------------------------------
// cmct_pkg
// shared sizes, payload types, register indexes and control structs for the
// context model counter table
// ----------------------------------------------------------------------------
package cmct_pkg;

    localparam int NUM_CONTEXTS = 65536;
    localparam int NUM_SYMBOLS  = 4;
    localparam int COUNT_BITS   = 16;

    localparam int CTX_BITS   = $clog2(NUM_CONTEXTS);
    localparam int SYM_SLOTS  = 4;
    localparam int SYM_BITS   = 2;
    localparam int REG_BITS   = 16;
    localparam int FREQ_BITS  = 32;
    localparam int TOTAL_BITS = 34;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_NUM = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_DEN = 2'd2;

    typedef logic [NUM_SYMBOLS-1:0][COUNT_BITS-1:0] row_t;

    typedef struct packed {
        logic                opcode;
        logic [15:0]         context_index;
        logic [SYM_BITS-1:0] symbol;
    } in_t;

    typedef struct packed {
        logic [FREQ_BITS-1:0]  freq_0;
        logic [FREQ_BITS-1:0]  freq_1;
        logic [FREQ_BITS-1:0]  freq_2;
        logic [FREQ_BITS-1:0]  freq_3;
        logic [TOTAL_BITS-1:0] total;
    } out_t;

    typedef struct packed {
        logic capture;
        logic clear_en;
        logic read_en;
        logic mul_en;
        logic add_en;
        logic total_en;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

// File: design/cmct_ctrl.sv
// ----------------------------------------------------------------------------
// cmct_ctrl
// sequencer: clearing pass after reset, then read, multiply, add and total
// steps for each item
// ----------------------------------------------------------------------------
module cmct_ctrl
    import cmct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_TOT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       accept;

    assign busy   = !(state_reg == ST_IDLE || state_reg == ST_TOT);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_TOT;
            ST_TOT:   state_next = accept ? ST_READ : ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_TOT);
        end
    end

    assign cmd.capture  = accept;
    assign cmd.clear_en = (state_reg == ST_CLEAR);
    assign cmd.read_en  = (state_reg == ST_READ);
    assign cmd.mul_en   = (state_reg == ST_MUL);
    assign cmd.add_en   = (state_reg == ST_ADD);
    assign cmd.total_en = (state_reg == ST_TOT);
    assign done         = done_reg;

endmodule

// File: design/cmct_datapath.sv
// ----------------------------------------------------------------------------
// cmct_datapath
// configuration registers, counter memory, row update, frequency and total
// arithmetic
// ----------------------------------------------------------------------------
module cmct_datapath
    import cmct_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  in_t                     item,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data,
    output out_t                    result
);

    logic [REG_BITS-1:0] max_count_reg;
    logic [REG_BITS-1:0] alpha_num_reg;
    logic [REG_BITS-1:0] alpha_den_reg;

    logic [CTX_BITS-1:0] clr_cnt_reg;
    logic [CTX_BITS-1:0] ctx_reg;
    logic                op_reg;
    logic [SYM_BITS-1:0] sym_reg;

    row_t mem [NUM_CONTEXTS];
    row_t row_reg;
    row_t row_next;
    logic upd;

    logic                wr_en;
    logic [CTX_BITS-1:0] wr_addr;
    row_t                wr_data;

    logic [NUM_SYMBOLS-1:0][FREQ_BITS-1:0] prod_reg;
    logic [SYM_SLOTS-1:0][FREQ_BITS-1:0]   freq_reg;
    logic [TOTAL_BITS-1:0]                 total_reg;
    logic [TOTAL_BITS-1:0]                 total_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= '0;
            alpha_num_reg <= REG_BITS'(1);
            alpha_den_reg <= REG_BITS'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_COUNT: max_count_reg <= cfg_data;
                CFG_ALPHA_NUM: alpha_num_reg <= cfg_data;
                CFG_ALPHA_DEN: alpha_den_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + CTX_BITS'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == CTX_BITS'(NUM_CONTEXTS - 1));

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ctx_reg <= item.context_index[CTX_BITS-1:0];
            op_reg  <= item.opcode;
            sym_reg <= item.symbol;
        end
    end

    // row update
    always_comb
    begin
        logic [COUNT_BITS-1:0] c;
        logic                  hit;
        c        = '0;
        hit      = 1'b0;
        row_next = row_reg;
        for (int s = 0; s < NUM_SYMBOLS; s++)
        begin
            if (sym_reg == SYM_BITS'(s))
            begin
                c           = row_reg[s] + COUNT_BITS'(1);
                hit         = 1'b1;
                row_next[s] = c;
            end
        end
        upd = op_reg && hit;
        if (max_count_reg != '0 && REG_BITS'(c) == max_count_reg)
        begin
            for (int s = 0; s < NUM_SYMBOLS; s++)
            begin
                row_next[s] = row_next[s] >> 1;
            end
        end
    end

    assign wr_en   = cmd.clear_en || (cmd.mul_en && upd);
    assign wr_addr = cmd.clear_en ? clr_cnt_reg : ctx_reg;
    assign wr_data = cmd.clear_en ? '0 : row_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            row_reg <= mem[ctx_reg];
        end
    end

    // arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            for (int s = 0; s < NUM_SYMBOLS; s++)
            begin
                prod_reg[s] <= FREQ_BITS'(alpha_den_reg) * FREQ_BITS'(row_reg[s]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_en)
        begin
            for (int s = 0; s < SYM_SLOTS; s++)
            begin
                if (s < NUM_SYMBOLS)
                begin
                    freq_reg[s] <= FREQ_BITS'(alpha_num_reg) + prod_reg[s];
                end
                else
                begin
                    freq_reg[s] <= '0;
                end
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int s = 0; s < NUM_SYMBOLS; s++)
        begin
            total_next = total_next + TOTAL_BITS'(freq_reg[s]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.total_en)
        begin
            total_reg <= total_next;
        end
    end

    assign result.freq_0 = freq_reg[0];
    assign result.freq_1 = freq_reg[1];
    assign result.freq_2 = freq_reg[2];
    assign result.freq_3 = freq_reg[3];
    assign result.total  = total_reg;

endmodule

// File: design/context_model_counter_table.sv
// ----------------------------------------------------------------------------
// context_model_counter_table
// per-context symbol counters with smoothed frequency and total reporting
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to zero, one row a cycle,
// through all 65536 rows (NUM_CONTEXTS); busy stays high meanwhile, and
// configuration writes are taken as usual. An item is taken when start is
// high and busy is low. Each item passes through a memory read, a multiply,
// an add and a total step; its result appears with done, high for one cycle,
// after the total step. A new item can be taken during the total step of
// the one before, not earlier: busy is high in its read, multiply and add
// steps. The receiver cannot stall: done is a one-cycle strobe.
module context_model_counter_table
    import cmct_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  in_t                     item,
    output logic                    done,
    output out_t                    result,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    cmct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cmct_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> cmd.read_en)
        else $error("accepted item not followed by a row read");

    a_total_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.total_en |=> done)
        else $error("total step not followed by done");

    a_done_after_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.total_en))
        else $error("done without a total step");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> (busy && !cmd.capture))
        else $error("item taken during clearing pass");
`endif

endmodule
